[hw/rtl/csbp_pkg.sv]
// Shared types and constants of the clock-sweep buffer pool frame table.
// Used by csbp_ctrl, csbp_dpath and clock_sweep_buffer_pool; no dependencies.
`default_nettype none

package csbp_pkg;

  // Default sizes of the pool.
  localparam int CSBP_FRAMES    = 64;
  localparam int CSBP_HANDS     = 4;
  localparam int CSBP_USAGE_MAX = 15;

  // Configuration register indexes.
  localparam int                 CFG_IDX_W         = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_FRAMES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE     = 1'b1;

  localparam logic [6:0]  ACTIVE_FRAMES_RST = 7'd64;
  localparam logic [16:0] PAGE_SIZE_RST     = 17'd4096;

  // Actions of an input item.
  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_LOADED    = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_FRAME  = 3'd4
  } csbp_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic setup;
    logic scan_step;
    logic hit_wr;
    logic rel_wr;
    logic res_noframe;
    logic res_notfound;
    logic mod_start;
    logic mod_step;
    logic swp_rd;
    logic swp_eval;
    logic out_load;
  } csbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic is_release;
    logic range_bad;
    logic scan_done;
    logic hit_found;
    logic hit_in_range;
    logic any_unpinned;
    logic mod_last;
    logic victim;
  } csbp_sts_t;

endpackage

`default_nettype wire

[hw/rtl/csbp_ctrl.sv]
// Controller state machine of the buffer pool frame table.
// Depends on csbp_pkg; drives csbp_dpath through command and status structs.
`default_nettype none

module csbp_ctrl
  import csbp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire csbp_sts_t sts,
  output csbp_cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_SETUP    = 9'b000000100,
    S_SEARCH   = 9'b000001000,
    S_DECIDE   = 9'b000010000,
    S_MOD      = 9'b000100000,
    S_SWP_RD   = 9'b001000000,
    S_SWP_EVAL = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_take;

  assign in_stall = (state != S_IDLE);
  assign out_take = out_valid && !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (!sts.is_release && sts.range_bad) begin
          cmd.res_noframe = 1'b1;
          state_next      = S_RESP;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_release) begin
          cmd.rel_wr       = sts.hit_found;
          cmd.res_notfound = !sts.hit_found;
          state_next       = S_RESP;
        end else if (sts.hit_in_range) begin
          cmd.hit_wr = 1'b1;
          state_next = S_RESP;
        end else if (!sts.any_unpinned) begin
          cmd.res_noframe = 1'b1;
          state_next      = S_RESP;
        end else begin
          cmd.mod_start = 1'b1;
          state_next    = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = S_SWP_RD;
        end
      end
      S_SWP_RD: begin
        cmd.swp_rd = 1'b1;
        state_next = S_SWP_EVAL;
      end
      S_SWP_EVAL: begin
        cmd.swp_eval = 1'b1;
        state_next   = sts.victim ? S_RESP : S_SWP_RD;
      end
      S_RESP: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/csbp_dpath.sv]
// Datapath of the buffer pool frame table: frame memory, clock hands,
// configuration registers, hand reduction unit and result registers. Uses csbp_pkg.
`default_nettype none

module csbp_dpath
  import csbp_pkg::*;
#(
  parameter int FRAMES    = CSBP_FRAMES,
  parameter int HANDS     = CSBP_HANDS,
  parameter int USAGE_MAX = CSBP_USAGE_MAX
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire csbp_cmd_t            cmd,
  output csbp_sts_t                 sts,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [16:0]          cfg_data,
  input  wire logic                 action,
  input  wire logic [15:0]          table_id,
  input  wire logic [31:0]          page_id,
  input  wire logic [23:0]          page_number,
  input  wire logic [1:0]           hand_select,
  input  wire logic [6:0]           range_first,
  input  wire logic [6:0]           range_last,
  output logic [2:0]                status,
  output logic [5:0]                slot,
  output logic                      evicted,
  output logic [31:0]               evicted_page_id,
  output logic [39:0]               read_offset
);

  localparam int FIDX_W = $clog2(FRAMES);
  localparam int HSEL_W = (HANDS > 1) ? $clog2(HANDS) : 1;
  localparam int USAGE_W = $clog2(USAGE_MAX + 1);
  localparam int STEP_W = $clog2(FIDX_W + 1);
  localparam int DIV_W = 2 * FIDX_W + 1;
  localparam logic [FIDX_W:0]    FRAMES_C = (FIDX_W + 1)'(FRAMES);
  localparam logic [USAGE_W-1:0] USAGE_TOP = USAGE_W'(USAGE_MAX);

  typedef struct packed {
    logic               valid;
    logic [15:0]        tab;
    logic [31:0]        page;
    logic               pinned;
    logic [USAGE_W-1:0] usage;
  } entry_t;

  // Hand select reduced into the number of stored hands.
  function automatic logic [HSEL_W-1:0] hsel_mod(input logic [1:0] v);
    logic [1:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if (int'(r) >= HANDS) begin
        r = r - 2'(HANDS);
      end
    end
    return HSEL_W'(r);
  endfunction

  // Configuration registers.
  logic [6:0]  active_frames;
  logic [16:0] page_size_bytes;

  // Latched item.
  logic              action_q;
  logic [15:0]       table_q;
  logic [31:0]       page_q;
  logic [23:0]       pnum_q;
  logic [HSEL_W-1:0] hsel_q;
  logic [6:0]        rf_q;
  logic [6:0]        rl_q;

  // Range and search state.
  logic [FIDX_W-1:0] rfirst;
  logic [FIDX_W-1:0] rlast;
  logic [FIDX_W:0]   rsize;
  logic              whole;
  logic [FIDX_W-1:0] whole_last;
  logic [FIDX_W:0]   scan_addr;
  logic              scan_pend;
  logic [FIDX_W-1:0] scan_ret;
  logic              found;
  logic              any_free;
  logic [FIDX_W-1:0] hit_idx;
  entry_t            hit_ent;

  // Frame memory.
  entry_t            mem [FRAMES];
  entry_t            rd_data;
  logic [FIDX_W-1:0] ra;
  logic              we;
  logic [FIDX_W-1:0] wa;
  entry_t            wd;
  logic [FIDX_W:0]   clr_cnt;

  // Clock hands and sweep.
  logic [FIDX_W-1:0] hand [HANDS];
  logic [FIDX_W-1:0] hcur;
  logic [FIDX_W-1:0] hnext;
  logic [FIDX_W-1:0] s_addr;
  logic [STEP_W-1:0] mod_k;
  logic [DIV_W-1:0]  mod_div;
  logic              victim;

  // Read offset product and results.
  logic [40:0]       prod_full;
  logic [39:0]       prod_q;
  csbp_status_t      res_status;
  logic [5:0]        res_slot;
  logic              res_ev;
  logic [31:0]       res_evp;
  logic [39:0]       res_off;

  assign whole = rf_q[6] && rl_q[6];
  always_comb begin
    if (active_frames == 7'd0) begin
      whole_last = '0;
    end else if (int'(active_frames) > FRAMES) begin
      whole_last = FIDX_W'(FRAMES - 1);
    end else begin
      whole_last = FIDX_W'(active_frames - 7'd1);
    end
  end

  assign rsize   = {1'b0, rlast} - {1'b0, rfirst} + (FIDX_W + 1)'(1);
  assign hnext   = (({1'b0, hcur} + (FIDX_W + 1)'(1)) == rsize) ? '0 : hcur + FIDX_W'(1);
  assign s_addr  = rfirst + hcur;
  assign mod_div = DIV_W'(rsize) << mod_k;
  assign victim  = !rd_data.pinned && (rd_data.usage == '0);
  assign prod_full = pnum_q * page_size_bytes;

  assign sts.clr_done     = (clr_cnt == FRAMES_C);
  assign sts.is_release   = (action_q == ACT_RELEASE);
  assign sts.range_bad    = !whole && (rf_q[6] || rl_q[6] || (rf_q[5:0] > rl_q[5:0])
                            || (int'(rl_q[5:0]) >= FRAMES));
  assign sts.scan_done    = (scan_addr == FRAMES_C) && !scan_pend;
  assign sts.hit_found    = found;
  assign sts.hit_in_range = found && (hit_idx >= rfirst) && (hit_idx <= rlast);
  assign sts.any_unpinned = any_free;
  assign sts.mod_last     = (mod_k == '0);
  assign sts.victim       = victim;

  // Read address: the sweep slot while sweeping, otherwise the scan pointer.
  always_comb begin
    if (cmd.swp_rd) begin
      ra = s_addr;
    end else if (scan_addr < FRAMES_C) begin
      ra = scan_addr[FIDX_W-1:0];
    end else begin
      ra = '0;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = s_addr;
    wd = rd_data;
    if (cmd.clr_step) begin
      we = 1'b1;
      wa = clr_cnt[FIDX_W-1:0];
      wd = '0;
    end else if (cmd.hit_wr) begin
      we        = 1'b1;
      wa        = hit_idx;
      wd        = hit_ent;
      wd.pinned = 1'b1;
      if (hit_ent.usage < USAGE_TOP) begin
        wd.usage = hit_ent.usage + USAGE_W'(1);
      end
    end else if (cmd.rel_wr) begin
      we        = 1'b1;
      wa        = hit_idx;
      wd        = hit_ent;
      wd.pinned = 1'b0;
    end else if (cmd.swp_eval) begin
      we = 1'b1;
      if (victim) begin
        wd.valid  = 1'b1;
        wd.tab    = table_q;
        wd.page   = page_q;
        wd.pinned = 1'b1;
        wd.usage  = USAGE_W'(1);
      end else if (rd_data.usage != '0) begin
        wd.usage = rd_data.usage - USAGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_frames   <= ACTIVE_FRAMES_RST;
      page_size_bytes <= PAGE_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE_FRAMES: active_frames   <= cfg_data[6:0];
        CFG_PAGE_SIZE:     page_size_bytes <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action_q <= action;
      table_q  <= table_id;
      page_q   <= page_id;
      pnum_q   <= page_number;
      hsel_q   <= hsel_mod(hand_select);
      rf_q     <= range_first;
      rl_q     <= range_last;
    end
    if (cmd.setup) begin
      rfirst <= whole ? '0 : FIDX_W'(rf_q[5:0]);
      rlast  <= whole ? whole_last : FIDX_W'(rl_q[5:0]);
    end
    prod_q <= prod_full[39:0];
  end

  // Tag search over all frames; one read issued and one checked per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      scan_pend <= 1'b0;
      found     <= 1'b0;
      any_free  <= 1'b0;
    end else if (cmd.setup) begin
      scan_addr <= '0;
      scan_pend <= 1'b0;
      found     <= 1'b0;
      any_free  <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_addr < FRAMES_C) begin
        scan_pend <= 1'b1;
        scan_ret  <= scan_addr[FIDX_W-1:0];
        scan_addr <= scan_addr + (FIDX_W + 1)'(1);
      end else begin
        scan_pend <= 1'b0;
      end
      if (scan_pend) begin
        if (rd_data.valid && (rd_data.tab == table_q) && (rd_data.page == page_q)
            && !found) begin
          found   <= 1'b1;
          hit_idx <= scan_ret;
          hit_ent <= rd_data;
        end
        if (!rd_data.pinned && (scan_ret >= rfirst) && (scan_ret <= rlast)) begin
          any_free <= 1'b1;
        end
      end
    end
  end

  // Clearing pass counter after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + (FIDX_W + 1)'(1);
    end
  end

  // Hand reduction by restoring subtraction, one quotient bit per cycle,
  // followed by the sweep itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HANDS; i++) begin
        hand[i] <= '0;
      end
      mod_k <= '0;
    end else begin
      if (cmd.mod_start) begin
        hcur  <= hand[hsel_q];
        mod_k <= STEP_W'(FIDX_W - 1);
      end else if (cmd.mod_step) begin
        if (DIV_W'(hcur) >= mod_div) begin
          hcur <= FIDX_W'(DIV_W'(hcur) - mod_div);
        end
        if (mod_k != '0) begin
          mod_k <= mod_k - STEP_W'(1);
        end
      end else if (cmd.swp_eval) begin
        if (victim) begin
          hand[hsel_q] <= hnext;
        end else begin
          hcur <= hnext;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hit_wr || cmd.rel_wr) begin
      res_status <= cmd.hit_wr ? ST_HIT : ST_RELEASED;
      res_slot   <= 6'(hit_idx);
      res_ev     <= 1'b0;
      res_evp    <= '0;
      res_off    <= '0;
    end else if (cmd.res_noframe || cmd.res_notfound) begin
      res_status <= cmd.res_noframe ? ST_NO_FRAME : ST_NOT_FOUND;
      res_slot   <= '0;
      res_ev     <= 1'b0;
      res_evp    <= '0;
      res_off    <= '0;
    end else if (cmd.swp_eval && victim) begin
      res_status <= ST_LOADED;
      res_slot   <= 6'(s_addr);
      res_ev     <= rd_data.valid;
      res_evp    <= rd_data.valid ? rd_data.page : '0;
      res_off    <= prod_q;
    end
    if (cmd.out_load) begin
      status          <= res_status;
      slot            <= res_slot;
      evicted         <= res_ev;
      evicted_page_id <= res_evp;
      read_offset     <= res_off;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/clock_sweep_buffer_pool.sv]
// Clock-sweep buffer pool frame table: lookup, pinning, release and victim
// selection. The top level instantiates csbp_ctrl and csbp_dpath; uses csbp_pkg.
//
// Use: an item enters on in_valid while in_stall is low and carries a request
// (action 0) or a release (action 1). Exactly one result item leaves on
// out_valid and is taken when out_stall is low. Items are worked on one at a
// time; in_stall stays high from acceptance until the result sits in the
// output register, so the next item can enter while that result still waits.
// Timing is set by the single read port of the frame memory. A release or a
// hit goes from acceptance to the output register through a setup state, a
// tag search over all frames, a decision state and a result load state. A
// request with a bad range skips the search. A load adds the hand reduction
// and a read and an evaluation state per visited frame; the sweep visits at
// most (USAGE_MAX + 1) passes over the range. After reset a clearing pass
// writes all FRAMES entries, one per cycle, and in_stall stays high until it
// ends. cfg_ready is always high; registers are to be written only while no
// item is in progress, which the block itself does not enforce. A stalled
// result holds the block after it has finished the next item.
`default_nettype none

module clock_sweep_buffer_pool
  import csbp_pkg::*;
#(
  parameter int FRAMES    = CSBP_FRAMES,
  parameter int HANDS     = CSBP_HANDS,
  parameter int USAGE_MAX = CSBP_USAGE_MAX
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 action,
  input  wire logic [15:0]          table_id,
  input  wire logic [31:0]          page_id,
  input  wire logic [23:0]          page_number,
  input  wire logic [1:0]           hand_select,
  input  wire logic signed [6:0]    range_first,
  input  wire logic signed [6:0]    range_last,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                status,
  output logic [5:0]                slot,
  output logic                      evicted,
  output logic [31:0]               evicted_page_id,
  output logic [39:0]               read_offset,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [16:0]          cfg_data
);

  csbp_cmd_t cmd;
  csbp_sts_t sts;

  assign cfg_ready = 1'b1;

  csbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  csbp_dpath #(
    .FRAMES    (FRAMES),
    .HANDS     (HANDS),
    .USAGE_MAX (USAGE_MAX)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .action          (action),
    .table_id        (table_id),
    .page_id         (page_id),
    .page_number     (page_number),
    .hand_select     (hand_select),
    .range_first     (range_first),
    .range_last      (range_last),
    .status          (status),
    .slot            (slot),
    .evicted         (evicted),
    .evicted_page_id (evicted_page_id),
    .read_offset     (read_offset)
  );

endmodule

`default_nettype wire
